// ===== sv/g2r_pkg.sv =====
package g2r_pkg;

    localparam int MAX_BRACE_DEPTH_DEF = 15;
    localparam int MAX_RUN             = 4;
    localparam int RUN_CNT_W           = $clog2(MAX_RUN + 1);
    localparam int RUN_IDX_W           = $clog2(MAX_RUN);

    typedef logic [7:0] t_byte;

    localparam t_byte CH_STAR   = 8'h2A;
    localparam t_byte CH_QUES   = 8'h3F;
    localparam t_byte CH_DOT    = 8'h2E;
    localparam t_byte CH_LPAR   = 8'h28;
    localparam t_byte CH_RPAR   = 8'h29;
    localparam t_byte CH_PLUS   = 8'h2B;
    localparam t_byte CH_PIPE   = 8'h7C;
    localparam t_byte CH_CARET  = 8'h5E;
    localparam t_byte CH_DOLLAR = 8'h24;
    localparam t_byte CH_AT     = 8'h40;
    localparam t_byte CH_PCT    = 8'h25;
    localparam t_byte CH_BSL    = 8'h5C;
    localparam t_byte CH_LBRACE = 8'h7B;
    localparam t_byte CH_RBRACE = 8'h7D;
    localparam t_byte CH_COMMA  = 8'h2C;

    typedef struct packed {
        t_byte [MAX_RUN-1:0]  bytes;
        logic [RUN_CNT_W-1:0] count;
        logic                 eop;
    } t_group;

endpackage

// ===== sv/g2r_in_if.sv =====
interface g2r_in_if;
    import g2r_pkg::*;

    logic  valid;
    logic  ready;
    t_byte glob_byte;
    logic  first_of_glob;
    logic  last_of_glob;

    modport source (output valid, output glob_byte, output first_of_glob,
                    output last_of_glob, input ready);
    modport sink   (input valid, input glob_byte, input first_of_glob,
                    input last_of_glob, output ready);
endinterface

// ===== sv/g2r_out_if.sv =====
interface g2r_out_if;
    import g2r_pkg::*;

    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  last_of_run;
    logic  end_of_pattern;

    modport source (output valid, output out_byte, output last_of_run,
                    output end_of_pattern, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input end_of_pattern, output ready);
endinterface

// ===== sv/g2r_xlate.sv =====
module g2r_xlate
    import g2r_pkg::*;
#(
    parameter int MAX_BRACE_DEPTH = MAX_BRACE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_take,
    input  t_byte  i_glob_byte,
    input  logic   i_first,
    input  logic   i_last,
    output t_group o_group
);

    localparam int DEPTH_W = $clog2(MAX_BRACE_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_BRACE_DEPTH);

    logic               r_escape;
    logic [DEPTH_W-1:0] r_depth;
    logic               n_escape;
    logic [DEPTH_W-1:0] n_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape <= 1'b0;
            r_depth  <= '0;
        end else if (i_take) begin
            r_escape <= n_escape;
            r_depth  <= n_depth;
        end
    end

    always_comb begin
        logic               esc;
        logic [DEPTH_W-1:0] depth;
        logic [RUN_CNT_W-1:0] k;
        t_byte [MAX_RUN-1:0]  b;

        esc   = i_first ? 1'b0 : r_escape;
        depth = i_first ? '0 : r_depth;
        k     = '0;
        b     = '0;
        n_escape = 1'b0;
        n_depth  = depth;

        if (i_first) begin
            b[k[RUN_IDX_W-1:0]] = CH_CARET; k = k + 1'b1;
        end

        case (i_glob_byte)
            CH_STAR: begin
                b[k[RUN_IDX_W-1:0]] = esc ? CH_BSL : CH_DOT; k = k + 1'b1;
                b[k[RUN_IDX_W-1:0]] = CH_STAR; k = k + 1'b1;
            end
            CH_QUES: begin
                if (esc) begin
                    b[k[RUN_IDX_W-1:0]] = CH_BSL;  k = k + 1'b1;
                    b[k[RUN_IDX_W-1:0]] = CH_QUES; k = k + 1'b1;
                end else begin
                    b[k[RUN_IDX_W-1:0]] = CH_DOT;  k = k + 1'b1;
                end
            end
            CH_DOT, CH_LPAR, CH_RPAR, CH_PLUS, CH_PIPE,
            CH_CARET, CH_DOLLAR, CH_AT, CH_PCT: begin
                b[k[RUN_IDX_W-1:0]] = CH_BSL;      k = k + 1'b1;
                b[k[RUN_IDX_W-1:0]] = i_glob_byte; k = k + 1'b1;
            end
            CH_BSL: begin
                if (esc) begin
                    b[k[RUN_IDX_W-1:0]] = CH_BSL; k = k + 1'b1;
                    b[k[RUN_IDX_W-1:0]] = CH_BSL; k = k + 1'b1;
                end else begin
                    n_escape = 1'b1;
                end
            end
            CH_LBRACE: begin
                if (esc) begin
                    b[k[RUN_IDX_W-1:0]] = CH_BSL;    k = k + 1'b1;
                    b[k[RUN_IDX_W-1:0]] = CH_LBRACE; k = k + 1'b1;
                end else begin
                    b[k[RUN_IDX_W-1:0]] = CH_LPAR;   k = k + 1'b1;
                    if (depth < DEPTH_MAX) begin
                        n_depth = depth + 1'b1;
                    end
                end
            end
            CH_RBRACE: begin
                if (depth != '0 && !esc) begin
                    b[k[RUN_IDX_W-1:0]] = CH_RPAR;   k = k + 1'b1;
                    n_depth = depth - 1'b1;
                end else if (esc) begin
                    b[k[RUN_IDX_W-1:0]] = CH_BSL;    k = k + 1'b1;
                    b[k[RUN_IDX_W-1:0]] = CH_RBRACE; k = k + 1'b1;
                end else begin
                    b[k[RUN_IDX_W-1:0]] = CH_RBRACE; k = k + 1'b1;
                end
            end
            CH_COMMA: begin
                if (depth != '0 && !esc) begin
                    b[k[RUN_IDX_W-1:0]] = CH_PIPE;  k = k + 1'b1;
                end else if (esc) begin
                    b[k[RUN_IDX_W-1:0]] = CH_BSL;   k = k + 1'b1;
                    b[k[RUN_IDX_W-1:0]] = CH_COMMA; k = k + 1'b1;
                end else begin
                    b[k[RUN_IDX_W-1:0]] = CH_COMMA; k = k + 1'b1;
                end
            end
            default: begin
                b[k[RUN_IDX_W-1:0]] = i_glob_byte; k = k + 1'b1;
            end
        endcase

        if (i_last) begin
            b[k[RUN_IDX_W-1:0]] = CH_DOLLAR; k = k + 1'b1;
        end

        o_group.bytes = b;
        o_group.count = k;
        o_group.eop   = i_last;
    end

endmodule

// ===== sv/g2r_serial.sv =====
module g2r_serial
    import g2r_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_group    i_group,
    output logic      o_load_ok,
    g2r_out_if.source o_regex
);

    logic                 r_valid;
    t_byte [MAX_RUN-1:0]  r_bytes;
    logic [RUN_CNT_W-1:0] r_count;
    logic [RUN_IDX_W-1:0] r_idx;
    logic                 r_eop;
    logic                 last;
    logic                 xfer;

    assign last      = (RUN_CNT_W'(r_idx) == (r_count - 1'b1));
    assign xfer      = r_valid && o_regex.ready;
    assign o_load_ok = !r_valid || (xfer && last);

    assign o_regex.valid          = r_valid;
    assign o_regex.out_byte       = r_bytes[r_idx];
    assign o_regex.last_of_run    = last;
    assign o_regex.end_of_pattern = last && r_eop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (xfer) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_group.bytes;
            r_count <= i_group.count;
            r_eop   <= i_group.eop;
        end
    end

endmodule

// ===== sv/glob_to_regex_translator.sv =====
// Glob to regular-expression translator.
// Input channel i_glob carries one glob byte per transfer, with marks for the
// first and last byte of a glob. Output channel o_regex carries one regex
// byte per transfer; last_of_run marks the final byte caused by one input
// byte and end_of_pattern marks the closing '$'.
// The first result byte of an accepted item is on o_regex in the next
// cycle. Each input byte yields 0 to 4 output bytes, sent one per cycle
// while o_regex.ready is high from a result register; the next item is
// accepted in the cycle the last byte of the current run transfers. Items
// of one output byte stream at one per cycle while o_regex.ready is high.
// A lone backslash yields nothing and is accepted whenever ready is high.
// Reset (synchronous, active low) clears the escape flag, the brace depth
// and the result register's valid flag. When the receiver stalls, the result
// register holds its byte and i_glob.ready drops until the run drains.
module glob_to_regex_translator
    import g2r_pkg::*;
#(
    parameter int MAX_BRACE_DEPTH = MAX_BRACE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    g2r_in_if.sink    i_glob,
    g2r_out_if.source o_regex
);

    t_group group;
    logic   load;
    logic   load_ok;
    logic   accept;

    assign i_glob.ready = load_ok;
    assign accept       = i_glob.valid && i_glob.ready;
    assign load         = accept && (group.count != '0);

    g2r_xlate #(
        .MAX_BRACE_DEPTH(MAX_BRACE_DEPTH)
    ) u_xlate (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (accept),
        .i_glob_byte (i_glob.glob_byte),
        .i_first     (i_glob.first_of_glob),
        .i_last      (i_glob.last_of_glob),
        .o_group     (group)
    );

    g2r_serial u_serial (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_group   (group),
        .o_load_ok (load_ok),
        .o_regex   (o_regex)
    );

    a_first_caret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_glob.first_of_glob |=> o_regex.valid && o_regex.out_byte == CH_CARET)
        else $error("glob start did not lead with caret");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> o_regex.valid)
        else $error("loaded run not presented");

    a_eop_dollar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_regex.valid && o_regex.end_of_pattern |->
            o_regex.last_of_run && o_regex.out_byte == CH_DOLLAR)
        else $error("end of pattern not on closing dollar");

endmodule

// ===== bench/glob_to_regex_translator_tb.sv =====
`timescale 1ns / 1ps

module glob_to_regex_translator_tb;
    import g2r_pkg::*;

    localparam int ITEM_TARGET    = 470;
    localparam int IDLE_LIMIT     = 2000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_AFTER     = 150;

    typedef struct packed {
        t_byte data;
        logic  run_end;
        logic  pat_end;
    } t_regex_byte;

    class regex_scoreboard;
        bit           esc_pending;
        int unsigned  brace_level;
        t_regex_byte  run_q[$];
        t_regex_byte  regex_q[$];
        int unsigned  mismatches;
        int unsigned  globs_seen;

        function new();
            esc_pending = 1'b0;
            brace_level = 0;
            mismatches  = 0;
            globs_seen  = 0;
        endfunction

        function void emit(t_byte b, bit pat_end);
            t_regex_byte rb;
            rb.data    = b;
            rb.run_end = 1'b0;
            rb.pat_end = pat_end;
            run_q.push_back(rb);
        endfunction

        function void escaped_pair(t_byte b);
            emit(CH_BSL, 1'b0);
            emit(b, 1'b0);
        endfunction

        function void note_glob_byte(t_byte c, bit first, bit last);
            bit esc;
            run_q.delete();
            if (first) begin
                esc_pending = 1'b0;
                brace_level = 0;
                globs_seen++;
                emit(CH_CARET, 1'b0);
            end
            esc = esc_pending;
            esc_pending = 1'b0;
            case (c)
                CH_STAR: begin
                    if (esc) escaped_pair(CH_STAR);
                    else begin
                        emit(CH_DOT, 1'b0);
                        emit(CH_STAR, 1'b0);
                    end
                end
                CH_QUES: begin
                    if (esc) escaped_pair(CH_QUES);
                    else emit(CH_DOT, 1'b0);
                end
                CH_DOT, CH_LPAR, CH_RPAR, CH_PLUS, CH_PIPE,
                CH_CARET, CH_DOLLAR, CH_AT, CH_PCT: begin
                    escaped_pair(c);
                end
                CH_BSL: begin
                    if (esc) escaped_pair(CH_BSL);
                    else esc_pending = 1'b1;
                end
                CH_LBRACE: begin
                    if (esc) escaped_pair(CH_LBRACE);
                    else begin
                        emit(CH_LPAR, 1'b0);
                        if (brace_level < MAX_BRACE_DEPTH_DEF) brace_level++;
                    end
                end
                CH_RBRACE: begin
                    if (brace_level > 0 && !esc) begin
                        emit(CH_RPAR, 1'b0);
                        brace_level--;
                    end else if (esc) escaped_pair(CH_RBRACE);
                    else emit(CH_RBRACE, 1'b0);
                end
                CH_COMMA: begin
                    if (brace_level > 0 && !esc) emit(CH_PIPE, 1'b0);
                    else if (esc) escaped_pair(CH_COMMA);
                    else emit(CH_COMMA, 1'b0);
                end
                default: emit(c, 1'b0);
            endcase
            if (last) emit(CH_DOLLAR, 1'b1);
            if (run_q.size() > 0) run_q[run_q.size() - 1].run_end = 1'b1;
            foreach (run_q[i]) regex_q.push_back(run_q[i]);
        endfunction

        function void check_regex_byte(t_byte b, logic run_end, logic pat_end);
            t_regex_byte want;
            if (regex_q.size() == 0) begin
                $display("%0t: unexpected regex byte, expected none, actual %h", $time, b);
                mismatches++;
                return;
            end
            want = regex_q.pop_front();
            if (b !== want.data) begin
                $display("%0t: out_byte expected %h, actual %h", $time, want.data, b);
                mismatches++;
            end
            if (run_end !== want.run_end) begin
                $display("%0t: last_of_run expected %b, actual %b", $time, want.run_end, run_end);
                mismatches++;
            end
            if (pat_end !== want.pat_end) begin
                $display("%0t: end_of_pattern expected %b, actual %b", $time, want.pat_end,
                         pat_end);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return regex_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    g2r_in_if  glob_ch ();
    g2r_out_if regex_ch ();

    glob_to_regex_translator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_glob  (glob_ch.sink),
        .o_regex (regex_ch.source)
    );

    regex_scoreboard sb = new();

    int unsigned items_sent;
    int unsigned bytes_out;
    int unsigned burst_left;
    int unsigned idle_cycles;
    bit          long_hold_go;
    bit          long_hold_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (glob_ch.valid && glob_ch.ready)
                sb.note_glob_byte(glob_ch.glob_byte, glob_ch.first_of_glob,
                                  glob_ch.last_of_glob);
            if (regex_ch.valid && regex_ch.ready) begin
                sb.check_regex_byte(regex_ch.out_byte, regex_ch.last_of_run,
                                    regex_ch.end_of_pattern);
                bytes_out++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((glob_ch.valid && glob_ch.ready) || (regex_ch.valid && regex_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("glob_to_regex_translator_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned rx_cycle;
        int unsigned rx_mode;
        int unsigned hold_cnt;
        rx_cycle = 0;
        rx_mode  = 0;
        hold_cnt = 0;
        regex_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (long_hold_go && !long_hold_done) begin
                regex_ch.ready <= 1'b0;
                hold_cnt++;
                if (hold_cnt >= LONG_HOLD) long_hold_done = 1'b1;
            end else begin
                if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
                case (rx_mode)
                    0: regex_ch.ready <= 1'b1;
                    1: regex_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: regex_ch.ready <= ($urandom_range(0, 9) < 3);
                    default: regex_ch.ready <= (rx_cycle % 3 != 0);
                endcase
            end
        end
    end

    task automatic send_glob_byte(t_byte c, bit first, bit last);
        int unsigned gap;
        glob_ch.valid         <= 1'b1;
        glob_ch.glob_byte     <= c;
        glob_ch.first_of_glob <= first;
        glob_ch.last_of_glob  <= last;
        @(posedge i_clk);
        while (!glob_ch.ready) @(posedge i_clk);
        items_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                glob_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    function automatic t_byte pick_glob_char();
        t_byte       meta [9];
        int unsigned r;
        meta = '{CH_DOT, CH_LPAR, CH_RPAR, CH_PLUS, CH_PIPE,
                 CH_CARET, CH_DOLLAR, CH_AT, CH_PCT};
        r = $urandom_range(0, 99);
        if (r < 10) return CH_STAR;
        if (r < 18) return CH_QUES;
        if (r < 28) return CH_BSL;
        if (r < 38) return CH_LBRACE;
        if (r < 48) return CH_RBRACE;
        if (r < 56) return CH_COMMA;
        if (r < 66) return meta[$urandom_range(0, 8)];
        if (r < 90) return t_byte'($urandom_range(8'h61, 8'h7A));
        return t_byte'($urandom_range(0, 255));
    endfunction

    task automatic send_glob(int unsigned len, bit mark_first, bit mark_last);
        for (int unsigned i = 0; i < len; i++)
            send_glob_byte(pick_glob_char(), mark_first && i == 0,
                           mark_last && i == len - 1);
    endtask

    task automatic send_deep_brace_glob();
        int unsigned opens;
        opens = $urandom_range(14, 18);
        send_glob_byte(CH_LBRACE, 1'b1, 1'b0);
        for (int unsigned i = 1; i < opens; i++)
            send_glob_byte(($urandom_range(0, 3) == 0) ? pick_glob_char() : CH_LBRACE,
                           1'b0, 1'b0);
        for (int unsigned i = 0; i < opens + 2; i++)
            send_glob_byte((i % 3 == 0) ? CH_COMMA : CH_RBRACE, 1'b0, i == opens + 1);
    endtask

    initial begin
        int unsigned kind;
        items_sent     = 0;
        bytes_out      = 0;
        burst_left     = 0;
        idle_cycles    = 0;
        long_hold_go   = 1'b0;
        long_hold_done = 1'b0;
        i_rst_n                <= 1'b0;
        glob_ch.valid          <= 1'b0;
        glob_ch.glob_byte      <= '0;
        glob_ch.first_of_glob  <= 1'b0;
        glob_ch.last_of_glob   <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_glob_byte(8'h61, 1'b0, 1'b0);
        send_glob_byte(CH_STAR, 1'b1, 1'b0);
        send_glob_byte(CH_QUES, 1'b0, 1'b0);
        send_glob_byte(CH_DOT, 1'b0, 1'b0);
        send_glob_byte(CH_DOLLAR, 1'b0, 1'b0);
        send_glob_byte(CH_BSL, 1'b0, 1'b0);
        send_glob_byte(CH_BSL, 1'b0, 1'b0);
        send_glob_byte(CH_BSL, 1'b0, 1'b0);
        send_glob_byte(CH_STAR, 1'b0, 1'b0);
        send_glob_byte(CH_BSL, 1'b0, 1'b0);
        send_glob_byte(8'h62, 1'b0, 1'b0);
        send_glob_byte(CH_LBRACE, 1'b0, 1'b0);
        send_glob_byte(CH_COMMA, 1'b0, 1'b0);
        send_glob_byte(CH_BSL, 1'b0, 1'b0);
        send_glob_byte(CH_COMMA, 1'b0, 1'b0);
        send_glob_byte(CH_RBRACE, 1'b0, 1'b0);
        send_glob_byte(CH_RBRACE, 1'b0, 1'b0);
        send_glob_byte(CH_COMMA, 1'b0, 1'b0);
        send_glob_byte(8'h00, 1'b0, 1'b0);
        send_glob_byte(8'hFF, 1'b0, 1'b0);
        send_glob_byte(CH_BSL, 1'b0, 1'b1);
        send_glob_byte(CH_BSL, 1'b1, 1'b0);
        send_glob_byte(CH_LBRACE, 1'b0, 1'b1);
        send_glob_byte(CH_STAR, 1'b1, 1'b1);
        send_glob_byte(CH_BSL, 1'b1, 1'b0);
        send_glob_byte(CH_RBRACE, 1'b0, 1'b0);
        send_glob_byte(CH_BSL, 1'b0, 1'b0);
        send_glob_byte(CH_QUES, 1'b0, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 19);
            if (kind < 14)
                send_glob($urandom_range(1, 12), 1'b1, 1'b1);
            else if (kind < 15)
                send_deep_brace_glob();
            else if (kind < 17)
                send_glob($urandom_range(1, 8), $urandom_range(0, 1), $urandom_range(0, 1));
            else
                for (int unsigned i = $urandom_range(1, 6); i > 0; i--)
                    send_glob_byte(t_byte'($urandom_range(0, 255)), $urandom_range(0, 1),
                                   $urandom_range(0, 1));
            if (!long_hold_go && items_sent > HOLD_AFTER) long_hold_go <= 1'b1;
        end

        glob_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d glob bytes in %0d globs, %0d regex bytes checked,",
                 items_sent, sb.globs_seen, bytes_out);
        $display("with bursty input, varied output stalls and one long output hold-off");
        if (sb.mismatches == 0) begin
            $display("glob_to_regex_translator_tb: PASS");
        end else begin
            $display("glob_to_regex_translator_tb: FAIL");
        end
        $finish;
    end

endmodule
